// File: src/ois_pkg.sv
`timescale 1ns / 1ps
// types and codes shared by the ordered id set engine
package ois_pkg;

    typedef enum logic [2:0] {
        CMD_ADD      = 3'd0,
        CMD_REMOVE   = 3'd1,
        CMD_TOGGLE   = 3'd2,
        CMD_CONTAINS = 3'd3,
        CMD_CLEAR    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO_ID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    localparam int CMD_W      = 3;
    localparam int OBJ_ID_W   = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int REV_W      = 32;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 48;

endpackage

// File: src/ois_store.sv
`timescale 1ns / 1ps
// identifier store: one write port, one registered read port
module ois_store
    import ois_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  t_mem_ctl         i_ctl,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/ois_ctrl.sv
`timescale 1ns / 1ps
// sequencer: scans the store, shifts entries down on remove or toggle, appends on add or toggle
module ois_ctrl
    import ois_pkg::*;
#(
    parameter int SET_CAPACITY = 64,
    parameter int ID_BITS      = 32,
    parameter int AW           = 6,
    parameter int CW           = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [ID_BITS-1:0] i_id,
    output logic               o_ready,
    output logic               o_res_valid,
    input  logic               i_res_take,
    output t_status            o_status,
    output logic               o_was,
    output logic [CW-1:0]      o_count,
    output logic [REV_W-1:0]   o_rev,
    output t_mem_ctl           o_mem_ctl,
    output logic [AW-1:0]      o_rd_addr,
    output logic [AW-1:0]      o_wr_addr,
    output logic [ID_BITS-1:0] o_wr_data,
    input  logic [ID_BITS-1:0] i_rd_data
);

    localparam logic [CW-1:0] CAP = CW'(SET_CAPACITY);

    t_state             r_state, n_state;
    logic [CMD_W-1:0]   r_cmd;
    logic [ID_BITS-1:0] r_id;
    logic [CW-1:0]      r_addr, n_addr;
    logic               r_rvalid;
    logic [CW-1:0]      r_ridx;
    logic [CW-1:0]      r_count, n_count;
    logic [REV_W-1:0]   r_rev, n_rev;
    t_status            r_status, n_status;
    logic               r_was, n_was;

    logic          w_issue;
    logic          w_match;
    logic          w_scan_end;
    logic          w_lookup_cmd;
    logic          w_drop_cmd;
    logic          w_grow_cmd;
    logic          w_id_zero;
    logic [CW-1:0] w_dst;

    assign w_issue      = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_addr < r_count);
    assign w_match      = r_rvalid && (i_rd_data == r_id);
    assign w_scan_end   = !r_rvalid && (r_addr >= r_count);
    assign w_id_zero    = (i_id == '0);
    assign w_lookup_cmd = (i_cmd == CMD_ADD) || (i_cmd == CMD_REMOVE) ||
                          (i_cmd == CMD_TOGGLE) || (i_cmd == CMD_CONTAINS);
    assign w_drop_cmd   = (r_cmd == CMD_REMOVE) || (r_cmd == CMD_TOGGLE);
    assign w_grow_cmd   = (r_cmd == CMD_ADD) || (r_cmd == CMD_TOGGLE);
    // entry read at r_ridx moves one place down
    assign w_dst        = r_ridx - CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (w_lookup_cmd && !w_id_zero) ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                priority if (w_match) begin
                    n_state = w_drop_cmd ? S_SHIFT : S_FINISH;
                end else if (w_scan_end) begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                if (w_scan_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and memory control
    always_comb begin
        o_ready           = (r_state == S_IDLE);
        o_res_valid       = (r_state == S_FINISH);
        o_mem_ctl.rd_en   = w_issue;
        o_mem_ctl.wr_en   = 1'b0;
        o_rd_addr         = r_addr[AW-1:0];
        o_wr_addr         = w_dst[AW-1:0];
        o_wr_data         = i_rd_data;
        unique case (r_state)
            S_SCAN: begin
                if (w_scan_end && w_grow_cmd && (r_count < CAP)) begin
                    o_mem_ctl.wr_en = 1'b1;
                    o_wr_addr       = r_count[AW-1:0];
                    o_wr_data       = r_id;
                end
            end
            S_SHIFT: begin
                o_mem_ctl.wr_en = r_rvalid;
            end
            S_IDLE, S_FINISH: begin
                o_mem_ctl.wr_en = 1'b0;
            end
            default: o_mem_ctl.wr_en = 1'b0;
        endcase
    end

    // datapath next values
    always_comb begin
        n_addr   = w_issue ? (r_addr + CW'(1)) : r_addr;
        n_count  = r_count;
        n_rev    = r_rev;
        n_status = r_status;
        n_was    = r_was;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_addr   = '0;
                    n_was    = 1'b0;
                    n_status = (w_lookup_cmd && w_id_zero) ? ST_ZERO_ID : ST_OK;
                    if ((i_cmd == CMD_CLEAR) && (r_count != '0)) begin
                        n_count = '0;
                        n_rev   = r_rev + REV_W'(1);
                    end
                end
            end
            S_SCAN: begin
                priority if (w_match) begin
                    n_was = 1'b1;
                end else if (w_scan_end && w_grow_cmd) begin
                    if (r_count >= CAP) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                        n_rev   = r_rev + REV_W'(1);
                    end
                end
            end
            S_SHIFT: begin
                if (w_scan_end) begin
                    n_count = r_count - CW'(1);
                    n_rev   = r_rev + REV_W'(1);
                end
            end
            S_FINISH: begin
                n_addr = r_addr;
            end
            default: n_addr = r_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_addr   <= '0;
            r_rvalid <= 1'b0;
            r_count  <= '0;
            r_rev    <= '0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_rvalid <= w_issue;
            r_count  <= n_count;
            r_rev    <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx   <= r_addr;
        r_status <= n_status;
        r_was    <= n_was;
        if ((r_state == S_IDLE) && i_start) begin
            r_cmd <= i_cmd;
            r_id  <= i_id;
        end
    end

    assign o_status = r_status;
    assign o_was    = r_was;
    assign o_count  = r_count;
    assign o_rev    = r_rev;

endmodule

// File: src/ordered_id_set_engine.sv
`timescale 1ns / 1ps
// ordered id set engine: stream ports, result register, store and sequencer
// flow: clear, zero id and unknown commands go straight to the result register,
//   add, remove, toggle and contains first walk the members held in the store
// throughput: one item at a time, the input is ready again as soon as the result is
//   registered; the walk through the store makes one read per cycle
// reset: synchronous active low, empties the set and zeroes the revision, no clearing pass
module ordered_id_set_engine
    import ois_pkg::*;
#(
    parameter int SET_CAPACITY = 64,
    parameter int ID_BITS      = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // object_id[31:0]
    input  logic [CMD_W-1:0]    s_axis_tuser,  // cmd[2:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata   // status[1:0], was_member[2],
                                               // member_count[9:3], revision[41:10], zero pad
);

    localparam int AW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int CW = $clog2(SET_CAPACITY + 1);

    logic                      w_start;
    logic                      w_ready;
    logic                      w_res_valid;
    logic                      w_take;
    logic [ID_BITS+OBJ_ID_W-1:0] w_id_ext;
    logic [ID_BITS-1:0]        w_id;
    t_status                   w_status;
    logic                      w_was;
    logic [CW-1:0]             w_count;
    logic [CW+COUNT_W-1:0]     w_count_ext;
    logic [REV_W-1:0]          w_rev;
    t_mem_ctl                  w_mem_ctl;
    logic [AW-1:0]             w_rd_addr;
    logic [AW-1:0]             w_wr_addr;
    logic [ID_BITS-1:0]        w_wr_data;
    logic [ID_BITS-1:0]        w_rd_data;

    logic                r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;

    // identifier taken modulo 2^ID_BITS
    assign w_id_ext    = {{ID_BITS{1'b0}}, s_axis_tdata[OBJ_ID_W-1:0]};
    assign w_id        = w_id_ext[ID_BITS-1:0];
    assign w_count_ext = {{COUNT_W{1'b0}}, w_count};

    assign s_axis_tready = w_ready;
    assign w_start       = s_axis_tvalid && w_ready;
    assign w_take        = !r_m_valid || m_axis_tready;

    ois_ctrl #(
        .SET_CAPACITY (SET_CAPACITY),
        .ID_BITS      (ID_BITS),
        .AW           (AW),
        .CW           (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_cmd       (s_axis_tuser),
        .i_id        (w_id),
        .o_ready     (w_ready),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_take),
        .o_status    (w_status),
        .o_was       (w_was),
        .o_count     (w_count),
        .o_rev       (w_rev),
        .o_mem_ctl   (w_mem_ctl),
        .o_rd_addr   (w_rd_addr),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .i_rd_data   (w_rd_data)
    );

    ois_store #(
        .DEPTH (SET_CAPACITY),
        .WIDTH (ID_BITS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (w_mem_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_take) begin
            r_m_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_res_valid) begin
            r_m_data <= {6'b0, w_rev, w_count_ext[COUNT_W-1:0], w_was, w_status};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// File: src/ois_checker.sv
`timescale 1ns / 1ps
// port checker for the ordered id set engine and its bind
module ois_checker
    import ois_pkg::*;
#(
    parameter int SET_CAPACITY = 64
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [S_DATA_W-1:0] s_axis_tdata,
    input logic [CMD_W-1:0]    s_axis_tuser,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // one item in flight: input closes right after a beat is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("undefined status code");

    // rejected or full never reports a member
    a_fail_not_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK) |-> !m_axis_tdata[2])
        else $error("member flag set on a failed item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (SET_CAPACITY >= 128) || (m_axis_tdata[9:3] <= SET_CAPACITY))
        else $error("member count above capacity");

endmodule

bind ordered_id_set_engine ois_checker #(.SET_CAPACITY(SET_CAPACITY)) u_ois_checker (.*);
